// ===== rtl/shdd_pkg.sv =====
// Shared types, constants and calendar tables for the Solar Hijri date difference block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package shdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int ORDER_W = 2;
   localparam int COUNT_W = 21;
   localparam int RES_W   = 6;   // year mod 33 residue

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [RES_W:0]     CYCLE_YEARS = 7'd33;
   localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   // floor(y / 33) == (y * RECIP_33) >> RECIP_SHIFT for every y below 67650
   localparam int          RECIP_SHIFT = 21;
   localparam logic [15:0] RECIP_33    = 16'd63551;

   localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture both dates
      logic div_quo;    // register year / 33 of the selected date
      logic div_rem;    // register year mod 33 and the year base
      logic conv;       // form the day number of the selected date
      logic finish;     // compare and write the output register
      logic sel;        // 0: date A, 1: date B
   } shdd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
   } shdd_sts_type;

   function automatic logic is_leap_res(input logic [RES_W-1:0] r);
      case (r) inside
         6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // leap years among residues 0 .. r-1
   function automatic logic [3:0] leaps_before(input logic [RES_W-1:0] r);
      return 4'(r > 6'd1) + 4'(r > 6'd5) + 4'(r > 6'd9) + 4'(r > 6'd13)
           + 4'(r > 6'd17) + 4'(r > 6'd22) + 4'(r > 6'd26) + 4'(r > 6'd30);
   endfunction

   // days in the year before the first of month m
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      case (m)
         4'd1:    return 9'd0;
         4'd2:    return 9'd31;
         4'd3:    return 9'd62;
         4'd4:    return 9'd93;
         4'd5:    return 9'd124;
         4'd6:    return 9'd155;
         4'd7:    return 9'd186;
         4'd8:    return 9'd216;
         4'd9:    return 9'd246;
         4'd10:   return 9'd276;
         4'd11:   return 9'd306;
         4'd12:   return 9'd336;
         default: return 9'd0;
      endcase
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      if (m < 4'd7) return 5'd31;
      if (m < MONTHS_PER_YEAR) return 5'd30;
      return leap ? 5'd30 : 5'd29;
   endfunction

endpackage

// ===== rtl/shdd_ctrl.sv =====
// Sequencer for the date difference: splits each year by 33, converts, compares.
// Depends on shdd_pkg (command and status structs).
`timescale 1ns / 1ps

module shdd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output shdd_pkg::shdd_cmd_type cmd,
   input  shdd_pkg::shdd_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUO,
      ST_REM,
      ST_CONV,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             sel_ff, sel_in;
   logic             accept;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = ST_QUO;
            end
         end
         ST_QUO: begin
            cmd.div_quo = 1'b1;
            state_in    = ST_REM;
         end
         ST_REM: begin
            cmd.div_rem = 1'b1;
            state_in    = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_QUO;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

// ===== rtl/shdd_dp.sv =====
// Datapath: date capture, reciprocal divide by 33, day-number conversion, compare, output register.
// Depends on shdd_pkg (tables, constants, command and status structs).
`timescale 1ns / 1ps

module shdd_dp #(
   parameter int YEAR_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  shdd_pkg::shdd_cmd_type            cmd,
   output shdd_pkg::shdd_sts_type            sts,
   input  logic [shdd_pkg::DAY_W-1:0]        req_day_a,
   input  logic [shdd_pkg::MONTH_W-1:0]      req_month_a,
   input  logic [YEAR_BITS-1:0]              req_year_a,
   input  logic [shdd_pkg::DAY_W-1:0]        req_day_b,
   input  logic [shdd_pkg::MONTH_W-1:0]      req_month_b,
   input  logic [YEAR_BITS-1:0]              req_year_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [shdd_pkg::ORDER_W-1:0]      rsp_order,
   output logic [shdd_pkg::COUNT_W-1:0]      rsp_day_count,
   output logic                              rsp_bad_date
);

   // 366 * 2**YEAR_BITS bounds every day number
   localparam int DN_W   = YEAR_BITS + 9;
   localparam int CW     = (DN_W + 1 > shdd_pkg::COUNT_W) ? DN_W + 1 : shdd_pkg::COUNT_W;
   localparam int RW     = shdd_pkg::RES_W;
   localparam int PROD_W = YEAR_BITS + 16;

   // captured dates
   logic [shdd_pkg::DAY_W-1:0]   day_a_ff, day_b_ff;
   logic [shdd_pkg::MONTH_W-1:0] month_a_ff, month_b_ff;
   logic [YEAR_BITS-1:0]         year_a_ff, year_b_ff;

   // divide by 33
   logic [PROD_W-1:0]    prod;
   logic [YEAR_BITS-1:0] quo_ff;
   logic [RW-1:0]        rem_ff;
   logic [DN_W-1:0]      base_ff;

   // conversion
   logic [shdd_pkg::DAY_W-1:0]   day_s;
   logic [shdd_pkg::MONTH_W-1:0] month_s;
   logic [YEAR_BITS-1:0]         year_s;
   logic [DN_W-1:0]              dn_s;
   logic                         ok_s;
   logic [DN_W-1:0]              dn_a_ff, dn_b_ff;
   logic                         bad_ff;

   // compare
   logic [CW-1:0]                diff;
   logic [shdd_pkg::COUNT_W-1:0] count_s;
   logic [shdd_pkg::ORDER_W-1:0] order_s;

   logic                         rsp_valid_ff;
   logic [shdd_pkg::ORDER_W-1:0] order_ff;
   logic [shdd_pkg::COUNT_W-1:0] count_ff;
   logic                         bad_out_ff;

   assign day_s   = cmd.sel ? day_b_ff   : day_a_ff;
   assign month_s = cmd.sel ? month_b_ff : month_a_ff;
   assign year_s  = cmd.sel ? year_b_ff  : year_a_ff;

   assign prod = PROD_W'(year_s) * PROD_W'(shdd_pkg::RECIP_33);

   always_comb begin
      dn_s = base_ff
           + DN_W'(shdd_pkg::leaps_before(rem_ff))
           + DN_W'(shdd_pkg::month_offset(month_s))
           + DN_W'(day_s) - DN_W'(1);
      ok_s = (month_s != '0) && (month_s <= shdd_pkg::MONTHS_PER_YEAR) && (day_s != '0)
          && (day_s <= shdd_pkg::month_len(month_s, shdd_pkg::is_leap_res(rem_ff)));
   end

   always_comb begin
      if (dn_a_ff < dn_b_ff) begin
         order_s = shdd_pkg::ORDER_EARLIER;
         diff    = CW'(dn_b_ff) - CW'(dn_a_ff) + CW'(1);
      end else if (dn_a_ff > dn_b_ff) begin
         order_s = shdd_pkg::ORDER_LATER;
         diff    = CW'(dn_a_ff) - CW'(dn_b_ff) + CW'(1);
      end else begin
         order_s = shdd_pkg::ORDER_EQUAL;
         diff    = '0;
      end
      count_s = (diff > CW'(shdd_pkg::COUNT_MAX)) ? shdd_pkg::COUNT_MAX
                                                  : diff[shdd_pkg::COUNT_W-1:0];
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         day_a_ff   <= req_day_a;
         month_a_ff <= req_month_a;
         year_a_ff  <= req_year_a;
         day_b_ff   <= req_day_b;
         month_b_ff <= req_month_b;
         year_b_ff  <= req_year_b;
         bad_ff     <= 1'b0;
      end
      if (cmd.div_quo) begin
         quo_ff <= YEAR_BITS'(prod >> shdd_pkg::RECIP_SHIFT);
      end
      if (cmd.div_rem) begin
         rem_ff  <= RW'(year_s - quo_ff * YEAR_BITS'(shdd_pkg::CYCLE_YEARS));
         base_ff <= DN_W'(year_s) * DN_W'(shdd_pkg::DAYS_PER_YEAR)
                  + DN_W'({quo_ff, 3'b000});
      end
      if (cmd.conv) begin
         if (cmd.sel) dn_b_ff <= dn_s;
         else         dn_a_ff <= dn_s;
         if (!ok_s) bad_ff <= 1'b1;
      end
      if (cmd.finish) begin
         order_ff   <= bad_ff ? shdd_pkg::ORDER_EARLIER : order_s;
         count_ff   <= bad_ff ? '0 : count_s;
         bad_out_ff <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_order     = order_ff;
   assign rsp_day_count = count_ff;
   assign rsp_bad_date  = bad_out_ff;

endmodule

// ===== rtl/solar_hijri_date_difference_top.sv =====
// Top level of the Solar Hijri date difference block.
// Depends on shdd_pkg, shdd_ctrl and shdd_dp.
`timescale 1ns / 1ps

// Compares two Solar Hijri dates (day, month, year) and returns their order
// (first earlier / equal / first later) and the inclusive day count between
// them: 0 for equal dates, else |dayno(A) - dayno(B)| + 1, saturated at the
// 21-bit maximum. An invalid date (month 0 or above 12, day 0, day past the
// month end) raises bad_date and zeroes order and day_count. The result
// register is written after these steps, per date in order: year / 33 by
// reciprocal multiply, year mod 33 and the year base, the day number; then
// the compare. The request side is free again on the cycle after that write;
// the compare waits while an earlier result still sits stalled in the output
// register. One item is in flight at a time; a new request beat is taken as
// soon as the previous result sits in the output register, even while that
// result is stalled.

module solar_hijri_date_difference_top #(
   parameter int YEAR_BITS = 12   // 8 .. 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [shdd_pkg::DAY_W-1:0]   req_day_a,
   input  logic [shdd_pkg::MONTH_W-1:0] req_month_a,
   input  logic [YEAR_BITS-1:0]         req_year_a,
   input  logic [shdd_pkg::DAY_W-1:0]   req_day_b,
   input  logic [shdd_pkg::MONTH_W-1:0] req_month_b,
   input  logic [YEAR_BITS-1:0]         req_year_b,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [shdd_pkg::ORDER_W-1:0] rsp_order,
   output logic [shdd_pkg::COUNT_W-1:0] rsp_day_count,
   output logic                         rsp_bad_date
);

   // Controller sequences: capture -> (divide year by 33, convert) for A,
   // then for B -> compare into the output register.
   shdd_pkg::shdd_cmd_type cmd;
   shdd_pkg::shdd_sts_type sts;

   shdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: year / 33 by reciprocal multiply, then
   // dayno = 365*y + 8*(y/33) + leaps before (y%33) + month offset + day - 1.
   shdd_dp #(
      .YEAR_BITS (YEAR_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_day_a     (req_day_a),
      .req_month_a   (req_month_a),
      .req_year_a    (req_year_a),
      .req_day_b     (req_day_b),
      .req_month_b   (req_month_b),
      .req_year_b    (req_year_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_order     (rsp_order),
      .rsp_day_count (rsp_day_count),
      .rsp_bad_date  (rsp_bad_date)
   );

endmodule

// ===== rtl/shdd_checker.sv =====
// Port-level checks for the Solar Hijri date difference block, bound to the top level.
// Depends on shdd_pkg and solar_hijri_date_difference_top.
`timescale 1ns / 1ps

module shdd_port_checks (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [shdd_pkg::ORDER_W-1:0] rsp_order,
   input logic [shdd_pkg::COUNT_W-1:0] rsp_day_count,
   input logic                         rsp_bad_date
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_order)
         && $stable(rsp_day_count) && $stable(rsp_bad_date))
      else $error("stalled result beat changed");

   // a bad date zeroes the other fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_date |-> rsp_order == shdd_pkg::ORDER_EARLIER
         && rsp_day_count == '0)
      else $error("bad date with nonzero results");

   // equal order exactly when the count is zero
   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_date |->
         (rsp_order == shdd_pkg::ORDER_EQUAL) == (rsp_day_count == '0))
      else $error("order and day count disagree");

   // one item at a time: busy right after an accepted request beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in flight");

endmodule

bind solar_hijri_date_difference_top shdd_port_checks u_shdd_port_checks (.*);

// ===== test/shdd_checker.sv =====
// Checker for the Solar Hijri date difference block: predicts order, day count and bad-date flag.
// Watches both channels of solar_hijri_date_difference_top; uses shdd_pkg for widths and order codes.
`timescale 1ns / 1ps

module shdd_checker #(
   parameter int YEAR_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [shdd_pkg::DAY_W-1:0]   req_day_a,
   input  logic [shdd_pkg::MONTH_W-1:0] req_month_a,
   input  logic [YEAR_BITS-1:0]         req_year_a,
   input  logic [shdd_pkg::DAY_W-1:0]   req_day_b,
   input  logic [shdd_pkg::MONTH_W-1:0] req_month_b,
   input  logic [YEAR_BITS-1:0]         req_year_b,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [shdd_pkg::ORDER_W-1:0] rsp_order,
   input  logic [shdd_pkg::COUNT_W-1:0] rsp_day_count,
   input  logic                         rsp_bad_date,
   input  logic                         end_check,
   output int                           fail_count,
   output int                           pending,
   output int                           checked
);

   typedef struct packed {
      logic [shdd_pkg::ORDER_W-1:0] order;
      logic [shdd_pkg::COUNT_W-1:0] day_count;
      logic                         bad_date;
   } span_type;

   span_type expected_spans[$];
   bit       end_done = 0;

   function automatic bit leap_year(input longint y);
      int r;
      r = int'(y % 33);
      return r == 1 || r == 5 || r == 9 || r == 13 || r == 17 || r == 22 || r == 26 ||
             r == 30;
   endfunction

   function automatic int days_in_month(input int m, input longint y);
      if (m < 7) return 31;
      if (m < 12) return 30;
      return leap_year(y) ? 30 : 29;
   endfunction

   function automatic bit date_ok(input int d, input int m, input longint y);
      if (m < 1 || m > 12 || d < 1) return 1'b0;
      return d <= days_in_month(m, y);
   endfunction

   // days since 1/1/0
   function automatic longint ordinal_day(input int d, input int m, input longint y);
      longint total;
      int     k;
      total = 365 * y + (y / 33) * 8;
      for (k = 0; k < int'(y % 33); k++)
         if (leap_year(k)) total++;
      if (m <= 7)
         total += 31 * (m - 1);
      else
         total += 186 + 30 * (m - 7);
      return total + d - 1;
   endfunction

   function automatic span_type predict_span(input int da, input int ma, input longint ya,
                                             input int db, input int mb, input longint yb);
      span_type s;
      longint   na;
      longint   nb;
      longint   cnt;
      s = '0;
      if (!date_ok(da, ma, ya) || !date_ok(db, mb, yb)) begin
         s.bad_date = 1'b1;
         return s;
      end
      na = ordinal_day(da, ma, ya);
      nb = ordinal_day(db, mb, yb);
      if (na == nb) begin
         s.order = shdd_pkg::ORDER_EQUAL;
         cnt = 0;
      end else if (na < nb) begin
         s.order = shdd_pkg::ORDER_EARLIER;
         cnt = nb - na + 1;
      end else begin
         s.order = shdd_pkg::ORDER_LATER;
         cnt = na - nb + 1;
      end
      if (cnt > longint'(shdd_pkg::COUNT_MAX)) cnt = longint'(shdd_pkg::COUNT_MAX);
      s.day_count = cnt[shdd_pkg::COUNT_W-1:0];
      return s;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      span_type want;
      if (reset) begin
         fail_count = 0;
         checked    = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_spans.push_back(predict_span(req_day_a, req_month_a, req_year_a,
                                                  req_day_b, req_month_b, req_year_b));
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_spans.size() == 0) begin
               report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_order !== want.order)
                  report_mismatch("order", rsp_order, want.order);
               if (rsp_day_count !== want.day_count)
                  report_mismatch("day_count", rsp_day_count, want.day_count);
               if (rsp_bad_date !== want.bad_date)
                  report_mismatch("bad_date", rsp_bad_date, want.bad_date);
            end
         end
         if (end_check && !end_done) begin
            end_done = 1;
            if (expected_spans.size() != 0)
               report_mismatch("results never delivered", 0, expected_spans.size());
         end
      end
      pending = expected_spans.size();
   end

endmodule

// ===== test/solar_hijri_date_difference_top_tb.sv =====
// Testbench top for solar_hijri_date_difference_top: stimulus, flow control and verdict.
// Depends on shdd_pkg, the block's RTL and shdd_checker.
`timescale 1ns / 1ps

module solar_hijri_date_difference_top_tb;

   localparam int YEAR_BITS   = 12;
   localparam int YEAR_MAX    = (1 << YEAR_BITS) - 1;
   localparam int RANDOM_BEATS = 1650;
   localparam int CHUNK_BEATS  = 110;   // beats per flow-control phase
   localparam int DRAIN_CYCLES = 40;    // extra wait after every result is back

   // flow-control phases
   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH
   } phase_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [shdd_pkg::DAY_W-1:0]     req_day_a = '0;
   logic [shdd_pkg::MONTH_W-1:0]   req_month_a = '0;
   logic [YEAR_BITS-1:0]           req_year_a = '0;
   logic [shdd_pkg::DAY_W-1:0]     req_day_b = '0;
   logic [shdd_pkg::MONTH_W-1:0]   req_month_b = '0;
   logic [YEAR_BITS-1:0]           req_year_b = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [shdd_pkg::ORDER_W-1:0]   rsp_order;
   logic [shdd_pkg::COUNT_W-1:0]   rsp_day_count;
   logic                           rsp_bad_date;
   logic                           end_check = 1'b0;

   int fail_count;
   int pending;
   int checked;
   int idle_pct  = 0;   // sender: chance in 100 of an idle cycle
   int stall_pct = 0;   // receiver: chance in 100 of a stalled cycle
   int sent = 0;

   always #10 clock = ~clock;

   solar_hijri_date_difference_top #(
      .YEAR_BITS(YEAR_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_day_a    (req_day_a),
      .req_month_a  (req_month_a),
      .req_year_a   (req_year_a),
      .req_day_b    (req_day_b),
      .req_month_b  (req_month_b),
      .req_year_b   (req_year_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_order    (rsp_order),
      .rsp_day_count(rsp_day_count),
      .rsp_bad_date (rsp_bad_date)
   );

   shdd_checker #(
      .YEAR_BITS(YEAR_BITS)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_day_a    (req_day_a),
      .req_month_a  (req_month_a),
      .req_year_a   (req_year_a),
      .req_day_b    (req_day_b),
      .req_month_b  (req_month_b),
      .req_year_b   (req_year_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_order    (rsp_order),
      .rsp_day_count(rsp_day_count),
      .rsp_bad_date (rsp_bad_date),
      .end_check    (end_check),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked)
   );

   // Receiver side: a fresh stall decision every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Hard stop in case the run never finishes.
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // Leap rule kept local so random dates can land on the last day of month 12.
   function automatic int month_days(input int m, input int y);
      int r;
      r = y % 33;
      if (m < 7) return 31;
      if (m < 12) return 30;
      return (r == 1 || r == 5 || r == 9 || r == 13 || r == 17 || r == 22 || r == 26 ||
              r == 30) ? 30 : 29;
   endfunction

   // One request beat. Called on a falling edge; returns on the falling edge after
   // the accepting rising edge, so valid can stay high into the next beat with a
   // single assignment per step.
   task automatic send_dates(input int da, input int ma, input int ya,
                             input int db, input int mb, input int yb);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_day_a   <= da[shdd_pkg::DAY_W-1:0];
      req_month_a <= ma[shdd_pkg::MONTH_W-1:0];
      req_year_a  <= ya[YEAR_BITS-1:0];
      req_day_b   <= db[shdd_pkg::DAY_W-1:0];
      req_month_b <= mb[shdd_pkg::MONTH_W-1:0];
      req_year_b  <= yb[YEAR_BITS-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // Drain: hold the sender off until every beat in flight has come back.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_phase(input phase_type ph);
      case (ph)
         PH_FREE: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         PH_SEND_IDLE: begin
            idle_pct  = 84;
            stall_pct = 0;
         end
         PH_RECV_STALL: begin
            idle_pct  = 0;
            stall_pct = 84;
         end
         default: begin
            idle_pct  = 32;
            stall_pct = 32;
         end
      endcase
   endtask

   task automatic pick_year(output int y);
      case ($urandom_range(9))
         0:       y = 0;
         1:       y = YEAR_MAX;
         2:       y = $urandom_range(66);
         default: y = $urandom_range(YEAR_MAX);
      endcase
   endtask

   // A random valid date; month ends are favored so the month-12 rule gets exercised.
   task automatic pick_date(output int d, output int m, output int y);
      pick_year(y);
      m = $urandom_range(12, 1);
      case ($urandom_range(3))
         0:       d = month_days(m, y);
         1:       d = 1;
         default: d = $urandom_range(month_days(m, y), 1);
      endcase
   endtask

   task automatic random_beat;
      int da, ma, ya, db, mb, yb;
      pick_date(da, ma, ya);
      pick_date(db, mb, yb);
      case ($urandom_range(9))
         0: yb = ya;                                  // same year
         1: begin                                     // same month
            yb = ya;
            mb = ma;
            db = $urandom_range(month_days(mb, yb), 1);
         end
         2: begin                                     // identical dates
            db = da;
            mb = ma;
            yb = ya;
         end
         3: begin                                     // neighboring year, maybe wrapping
            yb = (ya + $urandom_range(2) - 1) & YEAR_MAX;
            if (db > month_days(mb, yb)) db = month_days(mb, yb);
         end
         4, 5: begin                                  // raw field noise, mostly invalid
            da = $urandom_range(31);
            ma = $urandom_range(15);
            ya = $urandom_range(YEAR_MAX);
            db = $urandom_range(31);
            mb = $urandom_range(15);
            yb = $urandom_range(YEAR_MAX);
         end
         6: begin                                     // one date broken by one field
            if ($urandom_range(1)) db = $urandom_range(1) ? 0 : month_days(mb, yb) + 1;
            else ma = $urandom_range(1) ? 0 : $urandom_range(15, 13);
         end
         default: ;
      endcase
      send_dates(da, ma, ya, db, mb, yb);
   endtask

   initial begin
      int        i;
      phase_type ph;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, each order, month-12 leap rule, invalid fields.
      send_dates(1, 1, 0, 1, 1, 0);                 // equal at the origin
      send_dates(1, 1, 0, 2, 1, 0);                 // adjacent days, A earlier
      send_dates(2, 1, 0, 1, 1, 0);                 // adjacent days, A later
      send_dates(1, 1, 0, 29, 12, YEAR_MAX);        // widest span
      send_dates(29, 12, YEAR_MAX, 1, 1, 0);
      send_dates(30, 12, 1, 1, 1, 2);               // last day of a leap year
      send_dates(30, 12, 2, 1, 1, 2);               // day 30 of month 12 in a common year
      send_dates(29, 12, 2, 1, 1, 3);
      send_dates(0, 1, 100, 1, 1, 100);             // day zero
      send_dates(1, 0, 100, 1, 1, 100);             // month zero
      send_dates(1, 13, 100, 1, 1, 100);            // month past 12
      send_dates(31, 15, YEAR_MAX, 1, 1, 0);        // all-ones first date
      send_dates(1, 1, 5, 31, 7, 5);                // day past a 30-day month, second date
      send_dates(31, 6, 10, 1, 7, 10);              // half-year boundary
      send_dates(29, 12, 32, 1, 1, 33);             // 33-year cycle boundary
      send_dates(30, 12, 30, 30, 12, 4089);         // leap residue 30 in years 30 and 4089
      send_dates(0, 0, 0, 0, 0, 0);                 // both invalid
      send_dates(15, 8, 1403, 15, 8, 1403);
      send_dates(31, 1, YEAR_MAX, 1, 1, YEAR_MAX);
      send_dates(30, 11, 4094, 1, 12, 4094);
      send_dates(1, 1, 2048, 29, 12, 2047);         // year MSB flip
      send_dates(31, 31 % 16, 0, 31, 12, 0);
      drain();

      // Random part, phases rotating every chunk; each switch drains first.
      for (i = 0; i < RANDOM_BEATS; i++) begin
         if (i % CHUNK_BEATS == 0) begin
            drain();
            ph = phase_type'((i / CHUNK_BEATS) % 4);
            set_phase(ph);
         end
         random_beat();
      end

      req_valid <= 1'b0;
      set_phase(PH_FREE);
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      end_check <= 1'b1;
      repeat (2) @(negedge clock);

      $display("sent %0d request beats across four flow-control mixes; %0d results compared",
               sent, checked);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
